// File: hw/rtl/pap_pkg.sv
package pap_pkg;

  // Fixed field widths of the vertex and result words.
  localparam int COORD_BITS       = 24;
  localparam int AREA_W           = 57;
  localparam int PERIM_W          = 35;
  localparam int CROSS_W          = 60;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int CNT_W_DEF        = $clog2(MAX_VERTICES_DEF + 1);
  localparam int MIN_AREA_VERTS   = 3;

  // Shared multiplier takes coordinate differences, so it is one bit wider.
  localparam int MUL_W  = COORD_BITS + 1;
  localparam int PROD_W = 2 * MUL_W;
  // Radicand of the segment length and the root width.
  localparam int SQ_W   = PROD_W;
  localparam int ROOT_W = SQ_W / 2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] z;
    logic                         last;
    logic                         first;
  } qentry_t;

  typedef struct packed {
    logic    push;
    qentry_t entry;
  } q_push_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } q_head_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DRAIN,
    BK_SQRT,
    BK_COMMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    MS_PX_Z,
    MS_X_PZ,
    MS_DX_DX,
    MS_DZ_DZ,
    MS_X_FZ,
    MS_FX_Z
  } mul_step_t;

endpackage

// File: hw/rtl/pap_if.sv
interface pap_vertex_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pap_pkg::COORD_BITS-1:0] coord_x;
  logic signed [pap_pkg::COORD_BITS-1:0] coord_z;
  logic                                  last_vertex;

  modport source (output valid, output coord_x, output coord_z, output last_vertex,
                  input ready);
  modport sink (input valid, input coord_x, input coord_z, input last_vertex,
                output ready);
endinterface

interface pap_result_if #(
  parameter int CNT_W = pap_pkg::CNT_W_DEF
);
  logic                           valid;
  logic                           ready;
  logic [pap_pkg::AREA_W-1:0]     area;
  logic [pap_pkg::PERIM_W-1:0]    perimeter;
  logic [CNT_W-1:0]               vertex_total;
  logic                           overflow;

  modport source (output valid, output area, output perimeter, output vertex_total,
                  output overflow, input ready);
  modport sink (input valid, input area, input perimeter, input vertex_total,
                input overflow, output ready);
endinterface

// File: hw/rtl/polygon_area_perimeter_core.sv
// The back end takes one vertex at a time, paced by the 25-step square root and the six
// products that share one 25 x 25 multiplier; a two-word queue absorbs bursts.
// Reset (rst_n low at a clock edge, synchronous) empties the queue, drops any pending
// result word and clears the polygon accumulators, so the next vertex opens a polygon.
module polygon_area_perimeter_core #(
  parameter int MAX_VERTICES = pap_pkg::MAX_VERTICES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pap_vertex_if.sink   in_vtx,
  pap_result_if.source out_res
);
  import pap_pkg::*;

  // The front end accepts vertex words and marks each one that opens a polygon.
  // The queue decouples it from the back end, so input handshakes go on until it fills
  // while the back end iterates on a segment length or waits on a stalled result word.
  q_push_t push;
  logic    q_full;
  q_head_t head;
  logic    pop;

  pap_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (in_vtx),
    .push   (push),
    .q_full (q_full)
  );

  pap_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  // The back end runs the shoelace products, the segment square root and the
  // accumulators, and holds the finished result word in its output register.
  pap_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

// File: hw/rtl/pap_front.sv
module pap_front (
  input  logic             clk,
  input  logic             rst_n,
  pap_vertex_if.sink       in_vtx,
  output pap_pkg::q_push_t push,
  input  logic             q_full
);
  import pap_pkg::*;

  logic first_r;
  logic first_nxt;
  logic accept;

  assign in_vtx.ready = !q_full;
  assign accept       = in_vtx.valid && !q_full;

  // The vertex after a closing vertex, or the first one after reset, opens a polygon.
  always_comb begin
    push.push        = accept;
    push.entry.x     = in_vtx.coord_x;
    push.entry.z     = in_vtx.coord_z;
    push.entry.last  = in_vtx.last_vertex;
    push.entry.first = first_r;
    first_nxt        = accept ? in_vtx.last_vertex : first_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else begin
      first_r <= first_nxt;
    end
  end

endmodule

// File: hw/rtl/pap_queue.sv
module pap_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  pap_pkg::q_push_t push,
  output logic             full,
  output pap_pkg::q_head_t head,
  input  logic             pop
);
  import pap_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qentry_t          entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_push  = push.push && !full;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.entry = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// File: hw/rtl/pap_isqrt.sv
module pap_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pap_pkg::SQ_W-1:0]   radicand,
  output pap_pkg::sqrt_status_t      status,
  output logic [pap_pkg::ROOT_W-1:0] root
);
  import pap_pkg::*;

  // One result bit per cycle: restoring square root, ROOT_W iterations.
  logic [SQ_W-1:0] rem_r, rem_nxt;
  logic [SQ_W-1:0] res_r, res_nxt;
  logic [SQ_W-1:0] bit_r, bit_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [SQ_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(SQ_W-2){1'b0}}};
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign root        = res_r[ROOT_W-1:0];

endmodule

// File: hw/rtl/pap_back.sv
module pap_back #(
  parameter int MAX_VERTICES = pap_pkg::MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pap_pkg::q_head_t head,
  output logic             pop,
  pap_result_if.source     out_res
);
  import pap_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    logic load;
    logic mul_issue;
    logic sqrt_start;
    logic commit;
  } bk_ctl_t;

  bk_state_t state_r, state_nxt;
  bk_ctl_t   ctl;

  logic signed [COORD_BITS-1:0] cur_x_r, cur_z_r;
  logic                         cur_last_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_z_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_z_r;

  mul_step_t                step_r;
  mul_step_t                ptag_r;
  logic                     pvalid_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [MUL_W-1:0]  dx, dz;
  logic [CROSS_W-1:0]       p_ext;

  logic [CROSS_W-1:0] cross_sum_r;
  logic [CROSS_W-1:0] close_r;
  logic [SQ_W-1:0]    sq_r;
  logic [PERIM_W-1:0] len_sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;

  sqrt_status_t       sq_st;
  logic [ROOT_W-1:0]  root;

  logic [PERIM_W:0]   seg_sum;
  logic [PERIM_W-1:0] len_nxt;
  logic               cnt_full;
  logic [CNT_W-1:0]   cnt_inc;
  logic               ovf_inc;
  logic [CROSS_W-1:0] mag;
  logic [CROSS_W-2:0] half;
  logic [AREA_W-1:0]  area_sat;
  logic [AREA_W-1:0]  area_val;
  logic               can_write;

  logic               out_valid_r, out_valid_nxt;
  logic [AREA_W-1:0]  out_area_r;
  logic [PERIM_W-1:0] out_perim_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_ovf_r;

  pap_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.sqrt_start),
    .radicand (sq_r),
    .status   (sq_st),
    .root     (root)
  );

  assign can_write = !out_valid_r || out_res.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        if (step_r == MS_FX_Z) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_nxt = BK_SQRT;
      end
      BK_SQRT: begin
        if (sq_st.done) begin
          state_nxt = BK_COMMIT;
        end
      end
      BK_COMMIT: begin
        if (!cur_last_r || can_write) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      BK_IDLE:   ctl.load       = head.valid;
      BK_MUL:    ctl.mul_issue  = 1'b1;
      BK_DRAIN:  ctl.sqrt_start = 1'b1;
      BK_SQRT:   ctl            = '0;
      BK_COMMIT: ctl.commit     = !cur_last_r || can_write;
      default:   ctl            = '0;
    endcase
  end

  assign pop = ctl.load;

  // Shared multiplier operands, one product per step.
  assign dx = $signed({prev_x_r[COORD_BITS-1], prev_x_r})
            - $signed({cur_x_r[COORD_BITS-1], cur_x_r});
  assign dz = $signed({prev_z_r[COORD_BITS-1], prev_z_r})
            - $signed({cur_z_r[COORD_BITS-1], cur_z_r});

  always_comb begin
    op_a = $signed({cur_x_r[COORD_BITS-1], cur_x_r});
    op_b = $signed({cur_z_r[COORD_BITS-1], cur_z_r});
    case (step_r)
      MS_PX_Z: begin
        op_a = $signed({prev_x_r[COORD_BITS-1], prev_x_r});
        op_b = $signed({cur_z_r[COORD_BITS-1], cur_z_r});
      end
      MS_X_PZ: begin
        op_a = $signed({cur_x_r[COORD_BITS-1], cur_x_r});
        op_b = $signed({prev_z_r[COORD_BITS-1], prev_z_r});
      end
      MS_DX_DX: begin
        op_a = dx;
        op_b = dx;
      end
      MS_DZ_DZ: begin
        op_a = dz;
        op_b = dz;
      end
      MS_X_FZ: begin
        op_a = $signed({cur_x_r[COORD_BITS-1], cur_x_r});
        op_b = $signed({first_z_r[COORD_BITS-1], first_z_r});
      end
      MS_FX_Z: begin
        op_a = $signed({first_x_r[COORD_BITS-1], first_x_r});
        op_b = $signed({cur_z_r[COORD_BITS-1], cur_z_r});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;
  assign p_ext    = {{(CROSS_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Commit arithmetic: perimeter saturation, vertex count and area magnitude.
  always_comb begin
    seg_sum  = {1'b0, len_sum_r} + {{(PERIM_W+1-ROOT_W){1'b0}}, root};
    len_nxt  = seg_sum[PERIM_W] ? {PERIM_W{1'b1}} : seg_sum[PERIM_W-1:0];
    cnt_full = (cnt_r >= CNT_W'(MAX_VERTICES));
    cnt_inc  = cnt_full ? cnt_r : CNT_W'(cnt_r + 1'b1);
    ovf_inc  = ovf_r | cnt_full;
    mag      = close_r[CROSS_W-1] ? CROSS_W'(~close_r + 1'b1) : close_r;
    half     = mag[CROSS_W-1:1];
    area_sat = (|half[CROSS_W-2:AREA_W]) ? {AREA_W{1'b1}} : half[AREA_W-1:0];
    area_val = (cnt_inc < CNT_W'(MIN_AREA_VERTS)) ? '0 : area_sat;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit && cur_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pvalid_r    <= ctl.mul_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Polygon accumulators carry across vertices and are cleared on reset and after a closing vertex.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_sum_r <= '0;
      len_sum_r   <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
    end else if (ctl.commit) begin
      if (cur_last_r) begin
        cross_sum_r <= '0;
        len_sum_r   <= '0;
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
      end else begin
        len_sum_r <= len_nxt;
        cnt_r     <= cnt_inc;
        ovf_r     <= ovf_inc;
      end
    end else if (pvalid_r) begin
      case (ptag_r)
        MS_PX_Z: cross_sum_r <= cross_sum_r + p_ext;
        MS_X_PZ: cross_sum_r <= cross_sum_r - p_ext;
        default: cross_sum_r <= cross_sum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur_x_r    <= head.entry.x;
      cur_z_r    <= head.entry.z;
      cur_last_r <= head.entry.last;
      step_r     <= MS_PX_Z;
      // An opening vertex is its own predecessor, so its cross and length terms vanish.
      if (head.entry.first) begin
        first_x_r <= head.entry.x;
        first_z_r <= head.entry.z;
        prev_x_r  <= head.entry.x;
        prev_z_r  <= head.entry.z;
      end
    end else if (ctl.commit) begin
      prev_x_r <= cur_x_r;
      prev_z_r <= cur_z_r;
    end
    if (ctl.mul_issue) begin
      prod_r <= prod_nxt;
      ptag_r <= step_r;
      if (step_r != MS_FX_Z) begin
        step_r <= mul_step_t'(step_r + 3'd1);
      end
    end
    if (pvalid_r) begin
      case (ptag_r)
        MS_DX_DX: sq_r    <= prod_r;
        MS_DZ_DZ: sq_r    <= sq_r + prod_r;
        MS_X_FZ:  close_r <= cross_sum_r + p_ext;
        MS_FX_Z:  close_r <= close_r - p_ext;
        default:  sq_r    <= sq_r;
      endcase
    end
    if (ctl.commit && cur_last_r) begin
      out_area_r  <= area_val;
      out_perim_r <= len_nxt;
      out_cnt_r   <= cnt_inc;
      out_ovf_r   <= ovf_inc;
    end
  end

  // The reported vertex total is a fixed-width field whatever the vertex bound.
  assign out_res.valid        = out_valid_r;
  assign out_res.area         = out_area_r;
  assign out_res.perimeter    = out_perim_r;
  assign out_res.vertex_total = CNT_W_DEF'(out_cnt_r);
  assign out_res.overflow     = out_ovf_r;

  a_first_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> (head.entry.first == (cnt_r == '0)))
    else $error("opening-vertex flag disagrees with the vertex count");

  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_st.done |-> (state_r == BK_SQRT))
    else $error("square root finished outside its wait state");

  a_last_product_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MUL && step_r == MS_FX_Z) |=>
      (pvalid_r && ptag_r == MS_FX_Z && state_r == BK_DRAIN))
    else $error("closing product not drained");

  a_overflow_at_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CNT_W'(MAX_VERTICES)))
    else $error("overflow set below the vertex bound");

endmodule

// File: tb/tb_polygon_area_perimeter_core.sv
`timescale 1ns / 100ps

module tb_polygon_area_perimeter_core;
  import pap_pkg::*;

  // The clock period is 10 ns.
  // The drain wait at the end covers one closing vertex with some margin.
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_ITEMS   = 80;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic [63:0] CROSS_MASK = (64'd1 << CROSS_W) - 64'd1;
  localparam logic [63:0] PERIM_SAT  = (64'd1 << PERIM_W) - 64'd1;
  localparam logic [63:0] AREA_SAT   = (64'd1 << AREA_W) - 64'd1;

  // Ways of drawing random coordinates for one polygon.
  typedef enum int {
    CS_FULL,
    CS_SMALL,
    CS_EXTREME,
    CS_CLUSTER
  } coord_style_t;

  // One result word as the block reports it for a closed polygon.
  typedef struct packed {
    logic [AREA_W-1:0]    area;
    logic [PERIM_W-1:0]   perimeter;
    logic [CNT_W_DEF-1:0] vertex_total;
    logic                 overflow;
  } poly_result_t;

  logic clk;
  logic rst_n;

  pap_vertex_if vtx_bus ();
  pap_result_if #(.CNT_W(CNT_W_DEF)) res_bus ();

  polygon_area_perimeter_core #(
    .MAX_VERTICES(MAX_VERTICES_DEF)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (vtx_bus.sink),
    .out_res(res_bus.source)
  );

  // Result words that the predictor has worked out and the block has not yet sent.
  poly_result_t expected_polygons[$];

  // Predictor copy of the polygon accumulators. Coordinates are kept as 64-bit
  // two's complement patterns so that products wrap exactly as the block's math does.
  logic [63:0] acc_first_x;
  logic [63:0] acc_first_z;
  logic [63:0] acc_prev_x;
  logic [63:0] acc_prev_z;
  logic [63:0] acc_cross;
  logic [63:0] acc_perim;
  int          acc_count;
  bit          acc_ovf;

  int error_count;
  bit burst_mode;
  int ready_hold;
  bit ready_level;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floored integer square root, bit by bit from the top pair of bits down.
  function automatic logic [63:0] isqrt64(input logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = radicand;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] cross_term(input logic [63:0] ax, az, bx, bz);
    return ax * bz - bx * az;
  endfunction

  function automatic logic [63:0] diff_square(input logic [63:0] a, b);
    logic [63:0] d;
    d = a - b;
    if (d[63]) d = ~d + 64'd1;
    return d * d;
  endfunction

  function automatic void clear_polygon();
    acc_first_x = '0;
    acc_first_z = '0;
    acc_prev_x  = '0;
    acc_prev_z  = '0;
    acc_cross   = '0;
    acc_perim   = '0;
    acc_count   = 0;
    acc_ovf     = 1'b0;
  endfunction

  // Advances the predictor by one accepted vertex. Returns 1 and fills word when
  // the vertex closes a polygon, since only a closing vertex yields a result.
  function automatic bit shoelace_step(input logic signed [COORD_BITS-1:0] cx, cz,
                                       input bit last, output poly_result_t word);
    logic [63:0] x;
    logic [63:0] z;
    logic [63:0] seg;
    logic [63:0] closed;
    logic [63:0] mag;
    logic [63:0] area;
    x    = {{(64-COORD_BITS){cx[COORD_BITS-1]}}, cx};
    z    = {{(64-COORD_BITS){cz[COORD_BITS-1]}}, cz};
    word = '0;
    if (acc_count == 0) begin
      acc_first_x = x;
      acc_first_z = z;
    end else begin
      acc_cross = (acc_cross + cross_term(acc_prev_x, acc_prev_z, x, z)) & CROSS_MASK;
      seg       = isqrt64(diff_square(acc_prev_x, x) + diff_square(acc_prev_z, z));
      acc_perim = acc_perim + seg;
      if (acc_perim > PERIM_SAT || seg > PERIM_SAT) acc_perim = PERIM_SAT;
    end
    acc_prev_x = x;
    acc_prev_z = z;
    // The count holds at its bound; later vertices only raise the flag.
    if (acc_count >= MAX_VERTICES_DEF) acc_ovf = 1'b1;
    else acc_count++;
    if (!last) return 1'b0;
    // The closing term goes from the last vertex back to the first one.
    closed = (acc_cross + cross_term(x, z, acc_first_x, acc_first_z)) & CROSS_MASK;
    mag    = closed[CROSS_W-1] ? ((~closed + 64'd1) & CROSS_MASK) : closed;
    area   = mag >> 1;
    if (area > AREA_SAT) area = AREA_SAT;
    if (acc_count < MIN_AREA_VERTS) area = '0;
    word.area         = AREA_W'(area);
    word.perimeter    = PERIM_W'(acc_perim);
    word.vertex_total = CNT_W_DEF'(acc_count);
    word.overflow     = acc_ovf;
    clear_polygon();
    return 1'b1;
  endfunction

  // Idle length for either side: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord(
      input coord_style_t style, input logic signed [COORD_BITS-1:0] center);
    logic signed [COORD_BITS-1:0] v;
    case (style)
      CS_SMALL: begin
        v = COORD_BITS'($urandom_range(0, 2047)) - COORD_BITS'(1024);
      end
      CS_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = COORD_MIN;
          1:       v = COORD_MAX;
          2:       v = '0;
          3:       v = '1;
          default: v = COORD_BITS'(1);
        endcase
      end
      CS_CLUSTER: begin
        // Offsets may wrap past the range; the wrapped value is still a legal coordinate.
        v = center + COORD_BITS'($urandom_range(0, 8191)) - COORD_BITS'(4096);
      end
      default: begin
        v = COORD_BITS'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Sends one vertex word. The call starts and ends at a falling edge. Valid is
  // lowered only when a gap follows, so it never gets two assignments in one step.
  task automatic send_vertex(input logic signed [COORD_BITS-1:0] x, z, input bit last);
    int gap;
    poly_result_t word;
    gap = pick_gap();
    if (gap > 0) begin
      vtx_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx_bus.valid       <= 1'b1;
    vtx_bus.coord_x     <= x;
    vtx_bus.coord_z     <= z;
    vtx_bus.last_vertex <= last;
    do @(posedge clk); while (!vtx_bus.ready);
    // The word is accepted at this edge, so the predictor takes it now.
    if (shoelace_step(x, z, last, word)) expected_polygons.push_back(word);
    @(negedge clk);
  endtask

  // Short directed shapes: the extremes of the coordinates, the one- and two-vertex
  // cases, both orientations, a degenerate line and repeated points.
  task automatic test_directed_shapes();
    // A lone vertex gives a zero area and a zero perimeter.
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
    // Two vertices give the longest possible single segment and no area.
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    // The largest triangle the coordinate range allows.
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    // A 256 by 256 square, counterclockwise and then clockwise; the areas must match.
    send_vertex(24'sd0,   24'sd0,   1'b0);
    send_vertex(24'sd256, 24'sd0,   1'b0);
    send_vertex(24'sd256, 24'sd256, 1'b0);
    send_vertex(24'sd0,   24'sd256, 1'b1);
    send_vertex(24'sd0,   24'sd0,   1'b0);
    send_vertex(24'sd0,   24'sd256, 1'b0);
    send_vertex(24'sd256, 24'sd256, 1'b0);
    send_vertex(24'sd256, 24'sd0,   1'b1);
    // Three points on a line enclose nothing.
    send_vertex(24'sd0,   24'sd0,   1'b0);
    send_vertex(24'sd100, 24'sd100, 1'b0);
    send_vertex(24'sd200, 24'sd200, 1'b1);
    // Repeated points give zero-length segments.
    send_vertex(-24'sd1, -24'sd1, 1'b0);
    send_vertex(-24'sd1, -24'sd1, 1'b0);
    send_vertex(-24'sd1, -24'sd1, 1'b1);
  endtask

  // Mostly well-formed polygons of random size and content, with a share of
  // words whose last flag is random, and stretches in which neither side idles.
  task automatic test_random_polygons();
    int sent;
    int n;
    int pick;
    bit noise;
    bit last;
    coord_style_t style;
    logic signed [COORD_BITS-1:0] center;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 99) < 15);
      pick  = $urandom_range(0, 99);
      noise = 1'b0;
      if (pick < 8) n = 1;
      else if (pick < 16) n = 2;
      else if (pick < 76) n = $urandom_range(3, 8);
      else if (pick < 94) n = $urandom_range(9, 40);
      else begin
        noise = 1'b1;
        n = $urandom_range(1, 6);
      end
      style  = coord_style_t'($urandom_range(0, 3));
      center = COORD_BITS'($urandom);
      for (int i = 0; i < n; i++) begin
        last = noise ? bit'($urandom_range(0, 1)) : (i == n - 1);
        send_vertex(pick_coord(style, center), pick_coord(style, center), last);
      end
      sent += n;
    end
    // Random last flags can leave a polygon open; close it so it reports.
    if (acc_count != 0) send_vertex(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b1);
    burst_mode = 1'b0;
  endtask

  // Walks the corners of the full-range square again and again, so every
  // shoelace term is near its largest positive value and every segment spans
  // the full coordinate range along one axis.
  task automatic test_long_polygon(input int count, input bit fast);
    logic signed [COORD_BITS-1:0] corner_x[4];
    logic signed [COORD_BITS-1:0] corner_z[4];
    corner_x   = '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX};
    corner_z   = '{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN};
    burst_mode = fast;
    for (int i = 0; i < count; i++) begin
      send_vertex(corner_x[i % 4], corner_z[i % 4], i == count - 1);
    end
    burst_mode = 1'b0;
  endtask

  // The result side: ready runs high for a while, then stalls for a random gap.
  // In burst stretches it stays high. One assignment per falling edge.
  initial begin
    res_bus.ready = 1'b0;
    ready_hold    = 0;
    ready_level   = 1'b0;
    forever begin
      @(negedge clk);
      if (burst_mode) begin
        res_bus.ready <= 1'b1;
      end else begin
        if (ready_hold == 0) begin
          ready_level = !ready_level;
          ready_hold  = ready_level ? $urandom_range(1, 16) : pick_gap();
          if (ready_hold == 0) begin
            ready_level = 1'b1;
            ready_hold  = $urandom_range(1, 16);
          end
        end
        res_bus.ready <= ready_level;
        ready_hold--;
      end
    end
  end

  // Every result word accepted at a rising edge is compared with the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    poly_result_t got;
    poly_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.area         = res_bus.area;
      got.perimeter    = res_bus.perimeter;
      got.vertex_total = res_bus.vertex_total;
      got.overflow     = res_bus.overflow;
      if (expected_polygons.size() == 0) begin
        report_failure($sformatf(
            "%0t: result word with none expected: area %0d perim %0d cnt %0d ovf %0b",
            $time, got.area, got.perimeter, got.vertex_total, got.overflow));
      end else begin
        want = expected_polygons.pop_front();
        if (got.area !== want.area || got.perimeter !== want.perimeter ||
            got.vertex_total !== want.vertex_total || got.overflow !== want.overflow) begin
          report_failure($sformatf(
              {"%0t: mismatch: expected area %0d perim %0d cnt %0d ovf %0b,",
               " got area %0d perim %0d cnt %0d ovf %0b"},
              $time, want.area, want.perimeter, want.vertex_total, want.overflow,
              got.area, got.perimeter, got.vertex_total, got.overflow));
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    vtx_bus.valid       = 1'b0;
    vtx_bus.coord_x     = '0;
    vtx_bus.coord_z     = '0;
    vtx_bus.last_vertex = 1'b0;
    error_count         = 0;
    burst_mode          = 1'b0;
    clear_polygon();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_shapes();
    test_random_polygons();
    // A long polygon of the largest terms, sent without idling.
    test_long_polygon(LONG_ITEMS, 1'b1);

    vtx_bus.valid <= 1'b0;
    while (expected_polygons.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run ends well within this time, even with the longest stalls.
  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
